// ===== rtl/brb_pkg.sv =====
// Package for the byte ring buffer: request codes, field widths and reset constants.
// No dependencies; used by byte_ring_buffer_unit.
package brb_pkg;

	// Request kinds carried on the input tuser field
	typedef enum logic [2:0] {
		REQ_WRITE = 3'd0,
		REQ_READ  = 3'd1,
		REQ_PEEK  = 3'd2,
		REQ_DROP  = 3'd3,
		REQ_CLEAR = 3'd4
	} req_type_t;

	localparam int unsigned STORE_DEPTH_DEF = 256;
	localparam int unsigned CAP_RESET       = 256;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned REQ_W   = 3;

	// Packed widths of the stream words (rounded up to whole bytes)
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 40;

endpackage

// ===== rtl/byte_ring_buffer_unit.sv =====
// Byte ring buffer top level: circular byte queue over one synchronous byte memory.
// Depends on brb_pkg for request codes, widths and reset constants.
//
// Circular byte queue. Each input word is one request (write, read, peek, drop,
// clear) and yields exactly one output word with the byte, a success flag in
// tuser, the count moved and the queue status after the request. The block
// sustains one request per clock while the result side does not stall; an
// output word passes first through the registered read port of the byte memory
// and then through the output register. Head, tail and fill level update at
// the accept edge, so a request always sees the effect of the one before it; a
// write and a read never fall on the same request, so the memory needs no
// forwarding. The capacity register (cfg_wdata, 1..STORE_DEPTH, zero reads as
// one and larger values saturate) empties the queue when written; write it only
// while no request is in flight. Memory contents are not cleared at reset: only
// bytes written since the last emptying can ever be returned.
module byte_ring_buffer_unit #(
	parameter int unsigned STORE_DEPTH = brb_pkg::STORE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration: capacity_in_use
	input  logic                           cfg_we,
	input  logic [brb_pkg::COUNT_W-1:0]    cfg_wdata,
	// request stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] data_byte, [15:8] peek_offset, [24:16] drop_count, [31:25] zero
	input  logic [brb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [2:0] req_type
	input  logic [brb_pkg::REQ_W-1:0]      s_axis_tuser,
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [7:0] byte_out, [16:8] moved_count, [25:17] fill_level,
	// [34:26] free_space, [35] is_empty, [36] is_full, [39:37] zero
	output logic [brb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] done_res
	output logic                           m_axis_tuser
);

	localparam int unsigned PTR_W = $clog2(STORE_DEPTH);
	localparam int unsigned CW    = brb_pkg::COUNT_W;
	// wide enough for pointer + count sums and for STORE_DEPTH itself
	localparam int unsigned SW    = ((PTR_W > CW) ? PTR_W : CW) + 1;
	localparam int unsigned CAP_RST_I =
		(STORE_DEPTH < brb_pkg::CAP_RESET) ? STORE_DEPTH : brb_pkg::CAP_RESET;
	localparam logic [CW-1:0] CAP_RST = CW'(CAP_RST_I);
	localparam logic [SW-1:0] DEPTH_W = SW'(STORE_DEPTH);

	// queue state
	logic [CW-1:0]    cap_q;
	logic [CW-1:0]    held_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;

	// byte store
	logic [7:0] mem [STORE_DEPTH];

	// stage 1: memory read in flight
	logic          valid_s1;
	logic          done_s1;
	logic          rdout_s1;
	logic [7:0]    rd_s1;
	logic [CW-1:0] moved_s1;
	logic [CW-1:0] fill_s1;
	logic [CW-1:0] free_s1;

	// output register
	logic                           out_valid_q;
	logic [brb_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                           out_user_q;

	// handshakes
	logic in_acc;
	logic out_free;
	logic adv_s1;

	// request decode
	brb_pkg::req_type_t req;
	logic [7:0]    in_byte;
	logic [7:0]    in_offset;
	logic [CW-1:0] in_drop;

	// next-state datapath
	logic [CW-1:0]    drop_n;
	logic [CW-1:0]    head_step;
	logic [SW-1:0]    head_sum;
	logic [SW-1:0]    head_wrap;
	logic [SW-1:0]    tail_sum;
	logic [SW-1:0]    tail_wrap;
	logic [SW-1:0]    cap_ext;
	logic [CW-1:0]    held_n;
	logic [PTR_W-1:0] head_n;
	logic [PTR_W-1:0] tail_n;
	logic             done_n;
	logic             rdout_n;
	logic [CW-1:0]    moved_n;
	logic             mem_we;
	logic             mem_re;
	logic [PTR_W-1:0] rd_addr;
	logic [CW-1:0]    cap_wr;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign req       = brb_pkg::req_type_t'(s_axis_tuser);
	assign in_byte   = s_axis_tdata[7:0];
	assign in_offset = s_axis_tdata[15:8];
	assign in_drop   = s_axis_tdata[24:16];

	assign cap_ext = SW'(cap_q);

	// one wrap adder serves read, peek and drop off the head
	assign drop_n    = (in_drop < held_q) ? in_drop : held_q;
	assign head_sum  = SW'(head_q) + SW'(head_step);
	assign head_wrap = (head_sum >= cap_ext) ? (head_sum - cap_ext) : head_sum;
	assign tail_sum  = SW'(tail_q) + SW'(1'b1);
	assign tail_wrap = (tail_sum >= cap_ext) ? (tail_sum - cap_ext) : tail_sum;

	always_comb begin
		head_step = CW'(1'b1);
		held_n    = held_q;
		head_n    = head_q;
		tail_n    = tail_q;
		done_n    = 1'b0;
		rdout_n   = 1'b0;
		moved_n   = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		rd_addr   = head_q;
		unique case (req)
			brb_pkg::REQ_WRITE: begin
				if (held_q < cap_q) begin
					mem_we  = in_acc;
					tail_n  = tail_wrap[PTR_W-1:0];
					held_n  = held_q + CW'(1'b1);
					done_n  = 1'b1;
					moved_n = CW'(1'b1);
				end
			end
			brb_pkg::REQ_READ: begin
				if (held_q != '0) begin
					mem_re  = in_acc;
					head_n  = head_wrap[PTR_W-1:0];
					held_n  = held_q - CW'(1'b1);
					done_n  = 1'b1;
					rdout_n = 1'b1;
					moved_n = CW'(1'b1);
				end
			end
			brb_pkg::REQ_PEEK: begin
				head_step = CW'(in_offset);
				if (CW'(in_offset) < held_q) begin
					mem_re  = in_acc;
					rd_addr = head_wrap[PTR_W-1:0];
					done_n  = 1'b1;
					rdout_n = 1'b1;
				end
			end
			brb_pkg::REQ_DROP: begin
				head_step = drop_n;
				head_n    = head_wrap[PTR_W-1:0];
				held_n    = held_q - drop_n;
				moved_n   = drop_n;
			end
			brb_pkg::REQ_CLEAR: begin
				head_n = '0;
				tail_n = '0;
				held_n = '0;
			end
			default: begin
				// unknown request: status only
			end
		endcase
	end

	// capacity write: zero means one, saturate at the store depth
	always_comb begin
		cap_wr = cfg_wdata;
		if (cfg_wdata == '0) begin
			cap_wr = CW'(1'b1);
		end else if (SW'(cfg_wdata) > DEPTH_W) begin
			cap_wr = CW'(STORE_DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_RST;
			held_q <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_we) begin
			cap_q  <= cap_wr;
			held_q <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else if (in_acc) begin
			held_q <= held_n;
			head_q <= head_n;
			tail_q <= tail_n;
		end
	end

	// byte memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= in_byte;
		end
		if (mem_re) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			done_s1  <= done_n;
			rdout_s1 <= rdout_n;
			moved_s1 <= moved_n;
			fill_s1  <= held_n;
			free_s1  <= cap_q - held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_user_q <= done_s1;
			out_data_q <= {3'b000,
			               (fill_s1 == cap_q),
			               (fill_s1 == '0),
			               free_s1,
			               fill_s1,
			               moved_s1,
			               (rdout_s1 ? rd_s1 : 8'h00)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= cap_q)
		else $error("fill level above capacity");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SW'(head_q) < cap_ext) && (SW'(tail_q) < cap_ext))
		else $error("head or tail beyond capacity");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !cfg_we && (req == brb_pkg::REQ_WRITE) && (held_q < cap_q)
		|=> held_q == $past(held_q) + CW'(1'b1))
		else $error("accepted write did not raise fill level");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("pending result lost while output stalled");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for byte_ring_buffer_unit: directed and random request traffic, self-checking.
// Depends on brb_pkg and the byte_ring_buffer_unit RTL; reads no files.
`timescale 1ns / 1ps

module tb;

	// Request codes the block must ignore
	localparam logic [brb_pkg::REQ_W-1:0] REQ_RSVD5 = 3'd5;
	localparam logic [brb_pkg::REQ_W-1:0] REQ_RSVD6 = 3'd6;
	localparam logic [brb_pkg::REQ_W-1:0] REQ_RSVD7 = 3'd7;

	localparam int unsigned DEPTH       = brb_pkg::STORE_DEPTH_DEF;
	localparam int unsigned PTR_W       = $clog2(DEPTH);
	localparam int unsigned CYCLE_LIMIT = 150000;
	// Extra idle wait after the last expected result word has been checked
	localparam int unsigned DRAIN_WAIT  = 6;

	typedef struct {
		logic [brb_pkg::BYTE_W-1:0]  byte_out;
		logic                        done_res;
		logic [brb_pkg::COUNT_W-1:0] moved_count;
		logic [brb_pkg::COUNT_W-1:0] fill_level;
		logic [brb_pkg::COUNT_W-1:0] free_space;
		logic                        is_empty;
		logic                        is_full;
	} queue_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [brb_pkg::COUNT_W-1:0]    cfg_wdata;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	// [7:0] data_byte, [15:8] peek_offset, [24:16] drop_count
	logic [brb_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	// [2:0] req_type
	logic [brb_pkg::REQ_W-1:0]      s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	// [7:0] byte, [16:8] moved, [25:17] fill, [34:26] free, [35] empty, [36] full
	logic [brb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	// [0] done_res
	logic                           m_axis_tuser;

	// Shadow of the queue
	logic [brb_pkg::BYTE_W-1:0]  ring_mem [DEPTH];
	int unsigned                 rd_ptr;
	int unsigned                 wr_ptr;
	int unsigned                 level;
	logic [brb_pkg::COUNT_W-1:0] cap_reg;

	queue_result_t expected_results[$];
	int unsigned   sender_idle_pct;
	int unsigned   receiver_idle_pct;
	int unsigned   mismatch_count;
	int unsigned   requests_sent;
	int unsigned   results_checked;
	int unsigned   full_hits;

	byte_ring_buffer_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// zero reads as one, anything above the store depth saturates
	function automatic int unsigned eff_capacity();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > DEPTH)
			return DEPTH;
		return 32'(cap_reg);
	endfunction

	function automatic int unsigned ring_wrap(input int unsigned idx, input int unsigned cap);
		return (idx >= cap) ? idx - cap : idx;
	endfunction

	// Apply one accepted request to the shadow queue and queue up its result word
	task automatic predict_queue_response(input logic [brb_pkg::REQ_W-1:0] code,
			input logic [brb_pkg::BYTE_W-1:0] data, input logic [7:0] offset,
			input logic [brb_pkg::COUNT_W-1:0] count);
		int unsigned   cap;
		queue_result_t res;
		cap = eff_capacity();
		res = '{default: '0};
		case (code)
			brb_pkg::REQ_WRITE: begin
				if (level < cap) begin
					ring_mem[PTR_W'(wr_ptr)] = data;
					wr_ptr = ring_wrap(wr_ptr + 1, cap);
					level++;
					res.done_res = 1'b1;
					res.moved_count = 9'd1;
				end
			end
			brb_pkg::REQ_READ: begin
				if (level > 0) begin
					res.byte_out = ring_mem[PTR_W'(rd_ptr)];
					rd_ptr = ring_wrap(rd_ptr + 1, cap);
					level--;
					res.done_res = 1'b1;
					res.moved_count = 9'd1;
				end
			end
			brb_pkg::REQ_PEEK: begin
				if (offset < level) begin
					res.byte_out = ring_mem[PTR_W'(ring_wrap(rd_ptr + offset, cap))];
					res.done_res = 1'b1;
				end
			end
			brb_pkg::REQ_DROP: begin
				res.moved_count = brb_pkg::COUNT_W'((count < level) ? count : level);
				rd_ptr = ring_wrap(rd_ptr + res.moved_count, cap);
				level -= res.moved_count;
			end
			brb_pkg::REQ_CLEAR: begin
				rd_ptr = 0;
				wr_ptr = 0;
				level = 0;
			end
			default: ;
		endcase
		res.fill_level = brb_pkg::COUNT_W'(level);
		res.free_space = brb_pkg::COUNT_W'(cap - level);
		res.is_empty = (level == 0);
		res.is_full = (level == cap);
		if (res.is_full)
			full_hits++;
		expected_results.push_back(res);
	endtask

	// One request word; inputs move on the falling edge, acceptance seen on the rising one
	task automatic send_request(input logic [brb_pkg::REQ_W-1:0] code,
			input logic [brb_pkg::BYTE_W-1:0] data,
			input logic [7:0] offset, input logic [brb_pkg::COUNT_W-1:0] count);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= code;
		s_axis_tdata  <= {7'd0, count, offset, data};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_queue_response(code, data, offset, count);
		requests_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// Capacity write only with nothing in flight; it also empties the queue
	task automatic write_capacity(input logic [brb_pkg::COUNT_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cap_reg = value;
		rd_ptr = 0;
		wr_ptr = 0;
		level = 0;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$error("result word with no request pending");
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("byte_out", 32'(want.byte_out), 32'(m_axis_tdata[7:0]));
				check_field("done_res", 32'(want.done_res), 32'(m_axis_tuser));
				check_field("moved_count", 32'(want.moved_count), 32'(m_axis_tdata[16:8]));
				check_field("fill_level", 32'(want.fill_level), 32'(m_axis_tdata[25:17]));
				check_field("free_space", 32'(want.free_space), 32'(m_axis_tdata[34:26]));
				check_field("is_empty", 32'(want.is_empty), 32'(m_axis_tdata[35]));
				check_field("is_full", 32'(want.is_full), 32'(m_axis_tdata[36]));
			end
		end
	end

	// Result side backpressure
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);

	// Read, peek, drop and ignored codes against an empty queue
	task automatic test_empty_requests();
		send_request(brb_pkg::REQ_READ, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_PEEK, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_DROP, 8'h00, 8'd0, 9'd256);
		send_request(REQ_RSVD5, 8'hFF, 8'hFF, 9'h1FF);
		send_request(REQ_RSVD7, 8'h00, 8'd0, 9'd0);
	endtask

	// Byte extremes through the queue, peeks inside and past the fill level, clamped drop
	task automatic test_write_peek_read();
		send_request(brb_pkg::REQ_WRITE, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_WRITE, 8'hFF, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_WRITE, 8'hA5, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_PEEK, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_PEEK, 8'h00, 8'd2, 9'd0);
		send_request(brb_pkg::REQ_PEEK, 8'h00, 8'd3, 9'd0);
		send_request(brb_pkg::REQ_PEEK, 8'h00, 8'd255, 9'd0);
		send_request(brb_pkg::REQ_READ, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_DROP, 8'h00, 8'd0, 9'h1FF);
		send_request(brb_pkg::REQ_READ, 8'h00, 8'd0, 9'd0);
	endtask

	// Capacity one, zero (reads as one) and oversize (saturates)
	task automatic test_capacity_limits();
		write_capacity(9'd1);
		send_request(brb_pkg::REQ_WRITE, 8'h5A, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_WRITE, 8'hC3, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_PEEK, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_READ, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_WRITE, 8'h11, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_CLEAR, 8'h00, 8'd0, 9'd0);
		write_capacity(9'd0);
		send_request(brb_pkg::REQ_WRITE, 8'h77, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_WRITE, 8'h88, 8'd0, 9'd0);
		send_request(REQ_RSVD6, 8'h00, 8'd0, 9'd0);
		write_capacity(9'h1FF);
		send_request(brb_pkg::REQ_WRITE, 8'h01, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_DROP, 8'h00, 8'd0, 9'd0);
		send_request(brb_pkg::REQ_READ, 8'h00, 8'd0, 9'd0);
	endtask

	// Random mix that alternates between filling and draining so full and empty get hit
	task automatic test_random_traffic(input logic [brb_pkg::COUNT_W-1:0] cfg_value,
			input int unsigned n_items, input int unsigned fill_pct);
		bit                          filling;
		int unsigned                 write_pct;
		int unsigned                 sub;
		logic [brb_pkg::REQ_W-1:0]   code;
		logic [7:0]                  offset;
		logic [brb_pkg::COUNT_W-1:0] count;
		write_capacity(cfg_value);
		filling = 1'b1;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (level == 0)
				filling = 1'b1;
			else if (level == eff_capacity())
				filling = 1'b0;
			else if ($urandom_range(99) < 4)
				filling = !filling;
			write_pct = filling ? fill_pct : 20;
			sub = $urandom_range(99);
			if ($urandom_range(99) < write_pct)
				code = brb_pkg::REQ_WRITE;
			else if (sub < 60)
				code = brb_pkg::REQ_READ;
			else if (sub < 80)
				code = brb_pkg::REQ_PEEK;
			else if (sub < 92)
				code = brb_pkg::REQ_DROP;
			else if (sub < 96)
				code = filling ? brb_pkg::REQ_READ : brb_pkg::REQ_CLEAR;
			else
				code = 3'($urandom_range(REQ_RSVD5, REQ_RSVD7));
			// peeks mostly land inside the held bytes
			if (level > 0 && $urandom_range(3) != 0)
				offset = 8'($urandom_range(level - 1));
			else
				offset = 8'($urandom_range(255));
			count = ($urandom_range(3) != 0) ? 9'($urandom_range(4)) : 9'($urandom_range(511));
			send_request(code, 8'($urandom_range(255)), offset, count);
		end
	endtask

	initial begin
		logic [brb_pkg::COUNT_W-1:0] caps [14];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		mismatch_count = 0;
		requests_sent = 0;
		results_checked = 0;
		full_hits = 0;
		rd_ptr = 0;
		wr_ptr = 0;
		level = 0;
		cap_reg = brb_pkg::COUNT_W'(brb_pkg::CAP_RESET);
		caps = '{9'd1, 9'd2, 9'd3, 9'd0, 9'd16,
		         9'd255, 9'd7, 9'd257, 9'd4, 9'd100,
		         9'd9, 9'h1FF, 9'd256, 9'd2};
		sender_idle_pct = 10;
		receiver_idle_pct = 84;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_empty_requests();
		test_write_peek_read();
		test_capacity_limits();
		for (int k = 0; k < 14; k++) begin
			if (k == 5) begin
				sender_idle_pct = 84;
				receiver_idle_pct = 10;
			end else if (k == 10) begin
				sender_idle_pct = 0;
				receiver_idle_pct = 0;
			end
			// the 9'h1FF setting (saturates) gets a long, write-heavy run
			if (k == 11)
				test_random_traffic(caps[k], 360, 95);
			else
				test_random_traffic(caps[k], 30, 70);
		end

		wait_idle();
		$display("tb: %0d requests, %0d result words checked, %0d at full level",
			requests_sent, results_checked, full_hits);
		$display("tb: capacities 1 to saturated depth, every request kind, ignored codes");
		if (mismatch_count == 0)
			$display("byte_ring_buffer_unit regression: pass");
		else
			$display("byte_ring_buffer_unit regression: fail");
		$finish;
	end

	// Watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb: cycle limit reached with %0d results outstanding", expected_results.size());
		$display("byte_ring_buffer_unit regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/brb_pkg.sv
rtl/byte_ring_buffer_unit.sv
tb/sv/tb.sv
